FILE: hdl/slt_pkg.sv
// shared types, codes and constants for the slew-limited level band tracker
// no dependencies; used by slt_mul and the top level
package slt_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIMPLE,
        ST_DEC_MUL,
        ST_SLEW_MUL,
        ST_DIV_RECIP,
        ST_DIV_BACK,
        ST_DIV_FIX,
        ST_EXP_A,
        ST_EXP_B,
        ST_EXP_C,
        ST_DECAY_MUL,
        ST_DECAY_FIN,
        ST_LEVEL,
        ST_BAND,
        ST_DONE
    } slt_state_t;

    // request kinds
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_STIM   = 2'd1;
    localparam logic [1:0] REQ_TARGET = 2'd2;

    // field widths fixed by the interface
    localparam int REQ_W     = 2;
    localparam int ELAPSED_W = 16;
    localparam int NOW_W     = 32;
    localparam int BAND_W    = 4;

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLEW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DWELL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_QUAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_EN    = 3'd4;
    localparam int RATE_W  = 24;
    localparam int DWELL_W = 16;

    // shared multiplier
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // divide by 1000 via reciprocal, quotient saturates at 2^20
    localparam int Q_W         = 21;
    localparam int N_W         = 30;
    localparam int NSUM_W      = 41;
    localparam int RECIP_SHIFT = 30;
    localparam logic [Q_W-1:0]    Q_SAT      = 21'h100000;
    localparam logic [NSUM_W-1:0] N_SAT      = 41'd1048576000;
    localparam logic [Q_W-1:0]    RECIP_1000 = 21'd1073741;
    localparam logic [9:0]        DIV_CONST  = 10'd1000;
    localparam logic [NSUM_W-1:0] DIV_HALF   = 41'd500;

    // q16 arithmetic
    localparam int Q16_W = 17;
    localparam logic [MUL_P_W-1:0] ROUND_Q16 = 56'd32768;

    // band thresholds in hundredths
    localparam int unsigned BAND_HUNDREDTHS [8] = '{5, 15, 30, 40, 55, 70, 85, 95};

    // exp(-n) in q16 for whole n, zero from 12 on
    function automatic logic [Q16_W-1:0] exp_whole_q16(input logic [4:0] idx);
        logic [Q16_W-1:0] res;
        case (idx)
            5'd0:    res = 17'd65536;
            5'd1:    res = 17'd24109;
            5'd2:    res = 17'd8869;
            5'd3:    res = 17'd3263;
            5'd4:    res = 17'd1200;
            5'd5:    res = 17'd442;
            5'd6:    res = 17'd162;
            5'd7:    res = 17'd60;
            5'd8:    res = 17'd22;
            5'd9:    res = 17'd8;
            5'd10:   res = 17'd3;
            5'd11:   res = 17'd1;
            default: res = 17'd0;
        endcase
        return res;
    endfunction

    // exp(-k/16) in q16
    function automatic logic [Q16_W-1:0] exp_sixteenth_q16(input logic [3:0] idx);
        logic [Q16_W-1:0] res;
        case (idx)
            4'd0:    res = 17'd65536;
            4'd1:    res = 17'd61565;
            4'd2:    res = 17'd57835;
            4'd3:    res = 17'd54331;
            4'd4:    res = 17'd51039;
            4'd5:    res = 17'd47947;
            4'd6:    res = 17'd45042;
            4'd7:    res = 17'd42313;
            4'd8:    res = 17'd39750;
            4'd9:    res = 17'd37341;
            4'd10:   res = 17'd35079;
            4'd11:   res = 17'd32954;
            4'd12:   res = 17'd30957;
            4'd13:   res = 17'd29081;
            4'd14:   res = 17'd27319;
            default: res = 17'd25664;
        endcase
        return res;
    endfunction

endpackage

FILE: hdl/slt_mul.sv
// shared unsigned multiplier with registered product
// depends on slt_pkg for operand widths
module slt_mul
    import slt_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/slew_limited_level_band_tracker.sv
// top level of the slew-limited level band tracker: sequencer, state and datapath
// depends on slt_pkg and slt_mul (the shared multiplier)
//
// usage
// - config port: cfg_we writes cfg_data into register cfg_index at the clock edge;
//   write only while the block is idle
// - input channel: in_valid / in_stall; an item is taken when in_valid is high and
//   in_stall is low; in_stall stays high from the take until the sequencer is back
//   in idle, so one item is in flight at a time
// - output channel: out_valid / out_stall; one result item per input item, held in
//   an output register until taken, so a new input item can be taken while it waits
// - sequence: stimulus, target and unknown items pass one simple state, then done;
//   ticks run the decay if the accumulator is nonzero, the slew step if enabled; a
//   divide by 1000 runs product, reciprocal and back-multiply on the shared 32x24
//   multiplier, then a fix-up; the decay adds the table exponential and scaling, the
//   slew step its own divide; level update, band decision and result load follow
// - a stalled receiver holds the finished result in the done state; the sequencer
//   moves on once the output register frees up
// - reset: asynchronous, active low; level 0.47, accumulator 0, band 4, timers 0,
//   config registers to their defaults; no clearing pass
module slew_limited_level_band_tracker
    import slt_pkg::*;
#(
    parameter int BAND_COUNT      = 9,
    parameter int TIME_BITS       = 32,
    parameter int LEVEL_FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]             cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [REQ_W-1:0]                  req_type,
    input  logic [ELAPSED_W-1:0]              elapsed_ms,
    input  logic [NOW_W-1:0]                  now_ms,
    input  logic signed [LEVEL_FRAC_BITS+1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              status,
    output logic [LEVEL_FRAC_BITS:0]          level,
    output logic [BAND_W-1:0]                 band,
    output logic                              changed,
    output logic signed [LEVEL_FRAC_BITS+1:0] accumulator
);

    // widths and constants that follow the level format
    localparam int LVL_W  = LEVEL_FRAC_BITS + 1;
    localparam int ACC_W  = LEVEL_FRAC_BITS + 2;
    localparam int SUM_W  = LEVEL_FRAC_BITS + 3;
    localparam int SH_L   = (LEVEL_FRAC_BITS >= 16) ? LEVEL_FRAC_BITS - 16 : 0;
    localparam int SH_R   = (LEVEL_FRAC_BITS < 16) ? 16 - LEVEL_FRAC_BITS : 0;
    localparam int STEP_W = Q_W + SH_L;
    localparam int NTHR   = (BAND_COUNT - 1 > 8) ? 8 : BAND_COUNT - 1;

    localparam longint unsigned ONE_L = 64'd1 << LEVEL_FRAC_BITS;
    localparam logic [LVL_W-1:0] ONE_LVL   = LVL_W'(ONE_L);
    localparam logic [LVL_W-1:0] LVL_RESET = LVL_W'((64'd47 * ONE_L + 64'd50) / 64'd100);
    localparam logic [LVL_W-1:0] TINY_MAG  = LVL_W'((ONE_L + 64'd999) / 64'd1000);
    localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(ONE_L);
    localparam logic [BAND_W-1:0] BAND_RESET = 4'd4;

    // sequencer
    slt_state_t state_reg, state_next;

    // configuration
    logic [RATE_W-1:0]  max_slew_reg;
    logic [RATE_W-1:0]  decay_rate_reg;
    logic [DWELL_W-1:0] min_dwell_reg;
    logic               dwell_qual_reg;
    logic               slew_en_reg;

    // tracker state
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [BAND_W-1:0]       band_reg, band_next;
    logic [BAND_W-1:0]       pending_band_reg, pending_band_next;
    logic [TIME_BITS-1:0]    last_change_reg, last_change_next;
    logic [TIME_BITS-1:0]    cross_time_reg, cross_time_next;
    logic                    sustained_reg, sustained_next;

    // latched item
    logic [REQ_W-1:0]        kind_reg, kind_next;
    logic [ELAPSED_W-1:0]    el_reg, el_next;
    logic [TIME_BITS-1:0]    now_reg, now_next;
    logic signed [ACC_W-1:0] val_reg, val_next;

    // working registers of the sequence
    logic               div_slew_reg, div_slew_next;
    logic               sat_reg, sat_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic [Q_W-1:0]     qe_reg, qe_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic [Q16_W-1:0]   f1_reg, f1_next;
    logic               status_reg, status_next;
    logic               changed_reg, changed_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic                    out_status_reg, out_status_next;
    logic [LVL_W-1:0]        out_level_reg, out_level_next;
    logic [BAND_W-1:0]       out_band_reg, out_band_next;
    logic                    out_changed_reg, out_changed_next;
    logic signed [ACC_W-1:0] out_acc_reg, out_acc_next;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;

    // handshake
    logic in_accept;
    logic out_free;

    // divide by 1000
    logic [NSUM_W-1:0] n_sum;
    logic              n_sat;
    logic [Q_W-1:0]    qe;
    logic [N_W-1:0]    rem;
    logic [Q_W-1:0]    q_fix;

    // exponential and decay
    logic [MUL_P_W-1:0]    prod_round;
    logic [4:0]            x_whole;
    logic [3:0]            x_k;
    logic [11:0]           x_r;
    logic [24:0]           rr_round;
    logic [Q16_W-1:0]      poly;
    logic [Q16_W-1:0]      factor;
    logic                  acc_neg;
    logic signed [ACC_W-1:0] acc_abs;
    logic [LVL_W-1:0]      acc_mag;
    logic [LVL_W-1:0]      dec_mag;
    logic [LVL_W-1:0]      dec_kept;
    logic signed [ACC_W-1:0] acc_dec;

    // level update
    logic signed [SUM_W-1:0] lvl_ext;
    logic signed [SUM_W-1:0] acc_ext;
    logic signed [SUM_W-1:0] goal_raw;
    logic [LVL_W-1:0]        goal_lvl;
    logic signed [SUM_W-1:0] diff;
    logic signed [SUM_W-1:0] diff_abs;
    logic [LVL_W-1:0]        diff_mag;
    logic [STEP_W-1:0]       step_lvl;

    // stimulus and target
    logic signed [SUM_W-1:0] v_sum;
    logic signed [SUM_W-1:0] acc_sum;
    logic signed [SUM_W-1:0] acc_clamp;
    logic signed [SUM_W-1:0] tgt_diff;

    // band decision
    logic [NTHR-1:0]      thr_hit;
    logic [BAND_W-1:0]    natural;
    logic [TIME_BITS-1:0] span_last;
    logic [TIME_BITS-1:0] span_cross;
    logic [TIME_BITS-1:0] dwell_t;
    logic                 band_take;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    slt_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // ---------------------------------------------------------------------
    // divide by 1000: reciprocal estimate is low by at most one
    // ---------------------------------------------------------------------
    assign n_sum = prod[NSUM_W-2:0] + DIV_HALF;
    assign n_sat = (n_sum >= N_SAT);
    assign qe    = prod[RECIP_SHIFT +: Q_W];
    assign rem   = n_reg - prod[N_W-1:0];
    assign q_fix = sat_reg ? Q_SAT
                           : qe_reg + ((rem >= N_W'(DIV_CONST)) ? Q_W'(1) : Q_W'(0));

    // ---------------------------------------------------------------------
    // exp(-x): whole part and sixteenths from tables, remainder by polynomial
    // ---------------------------------------------------------------------
    assign prod_round = prod + ROUND_Q16;
    assign x_whole    = q_reg[20:16];
    assign x_k        = q_reg[15:12];
    assign x_r        = q_reg[11:0];
    assign rr_round   = prod[24:0] + 25'd65536;
    assign poly       = 17'd65536 - Q16_W'(x_r) + Q16_W'(rr_round[24:17]);
    assign factor     = prod_round[16 +: Q16_W];

    // accumulator magnitude scaling, tiny remainders drop to zero
    assign acc_neg  = acc_reg[ACC_W-1];
    assign acc_abs  = acc_neg ? -acc_reg : acc_reg;
    assign acc_mag  = acc_abs[LVL_W-1:0];
    assign dec_mag  = prod_round[16 +: LVL_W];
    assign dec_kept = (dec_mag < TINY_MAG) ? '0 : dec_mag;
    assign acc_dec  = acc_neg ? -$signed({1'b0, dec_kept}) : $signed({1'b0, dec_kept});

    // ---------------------------------------------------------------------
    // level: goal clamped to 0..1, then, when slew is enabled, limited by the slew step
    // ---------------------------------------------------------------------
    assign lvl_ext  = $signed({2'b00, lvl_reg});
    assign acc_ext  = {acc_reg[ACC_W-1], acc_reg};
    assign goal_raw = lvl_ext + acc_ext;

    always_comb
    begin
        if (goal_raw < 0)
            goal_lvl = '0;
        else if (goal_raw > ONE_SUM)
            goal_lvl = ONE_LVL;
        else
            goal_lvl = goal_raw[LVL_W-1:0];
    end

    assign diff     = $signed({2'b00, goal_lvl}) - lvl_ext;
    assign diff_abs = (diff < 0) ? -diff : diff;
    assign diff_mag = diff_abs[LVL_W-1:0];
    // step in q16 rescaled to the level format
    assign step_lvl = (STEP_W'(q_reg) << SH_L) >> SH_R;

    // ---------------------------------------------------------------------
    // stimulus add and target load
    // ---------------------------------------------------------------------
    assign v_sum    = {val_reg[ACC_W-1], val_reg};
    assign acc_sum  = acc_ext + v_sum;
    assign tgt_diff = v_sum - lvl_ext;

    always_comb
    begin
        if (acc_sum < -ONE_SUM)
            acc_clamp = -ONE_SUM;
        else if (acc_sum > ONE_SUM)
            acc_clamp = ONE_SUM;
        else
            acc_clamp = acc_sum;
    end

    // ---------------------------------------------------------------------
    // band classification: one comparator per threshold in use
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < NTHR; g++)
    begin : g_thr
        localparam logic [LVL_W-1:0] THR =
            LVL_W'((64'(BAND_HUNDREDTHS[g]) * ONE_L + 64'd99) / 64'd100);
        assign thr_hit[g] = (lvl_reg >= THR);
    end

    // thresholds ascend, so the hit count is the band
    assign natural    = BAND_W'($countones(thr_hit));
    assign span_last  = now_reg - last_change_reg;
    assign span_cross = now_reg - cross_time_reg;
    assign dwell_t    = TIME_BITS'(min_dwell_reg);

    // ---------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type != REQ_TICK)
                        state_next = ST_SIMPLE;
                    else if (acc_reg != '0)
                        state_next = ST_DEC_MUL;
                    else if (slew_en_reg)
                        state_next = ST_SLEW_MUL;
                    else
                        state_next = ST_LEVEL;
                end
            end
            ST_SIMPLE:    state_next = ST_DONE;
            ST_DEC_MUL:   state_next = ST_DIV_RECIP;
            ST_SLEW_MUL:  state_next = ST_DIV_RECIP;
            ST_DIV_RECIP: state_next = ST_DIV_BACK;
            ST_DIV_BACK:  state_next = ST_DIV_FIX;
            ST_DIV_FIX:   state_next = div_slew_reg ? ST_LEVEL : ST_EXP_A;
            ST_EXP_A:     state_next = ST_EXP_B;
            ST_EXP_B:     state_next = ST_EXP_C;
            ST_EXP_C:     state_next = ST_DECAY_MUL;
            ST_DECAY_MUL: state_next = ST_DECAY_FIN;
            ST_DECAY_FIN: state_next = slew_en_reg ? ST_SLEW_MUL : ST_LEVEL;
            ST_LEVEL:     state_next = ST_BAND;
            ST_BAND:      state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // datapath and outputs of each state
    // ---------------------------------------------------------------------
    always_comb
    begin
        lvl_next          = lvl_reg;
        acc_next          = acc_reg;
        band_next         = band_reg;
        pending_band_next = pending_band_reg;
        last_change_next  = last_change_reg;
        cross_time_next   = cross_time_reg;
        sustained_next    = sustained_reg;
        kind_next         = kind_reg;
        el_next           = el_reg;
        now_next          = now_reg;
        val_next          = val_reg;
        div_slew_next     = div_slew_reg;
        sat_next          = sat_reg;
        n_next            = n_reg;
        qe_next           = qe_reg;
        q_next            = q_reg;
        f1_next           = f1_reg;
        status_next       = status_reg;
        changed_next      = changed_reg;
        // a taken result empties the output register
        out_valid_next    = out_valid_reg && out_stall;
        out_status_next   = out_status_reg;
        out_level_next    = out_level_reg;
        out_band_next     = out_band_reg;
        out_changed_next  = out_changed_reg;
        out_acc_next      = out_acc_reg;
        mul_a             = '0;
        mul_b             = '0;
        band_take         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next    = req_type;
                    el_next      = elapsed_ms;
                    now_next     = TIME_BITS'(now_ms);
                    val_next     = value;
                    status_next  = 1'b0;
                    changed_next = 1'b0;
                end
            end
            ST_SIMPLE:
            begin
                case (kind_reg)
                    REQ_STIM:
                    begin
                        if (v_sum < -ONE_SUM || v_sum > ONE_SUM)
                            status_next = 1'b1;
                        else
                            acc_next = acc_clamp[ACC_W-1:0];
                    end
                    REQ_TARGET:
                    begin
                        if (v_sum < 0 || v_sum > ONE_SUM)
                            status_next = 1'b1;
                        else
                            acc_next = tgt_diff[ACC_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DEC_MUL:
            begin
                // decay exponent numerator: rate times elapsed ms
                div_slew_next = 1'b0;
                mul_a         = MUL_A_W'(decay_rate_reg);
                mul_b         = MUL_B_W'(el_reg);
            end
            ST_SLEW_MUL:
            begin
                div_slew_next = 1'b1;
                mul_a         = MUL_A_W'(max_slew_reg);
                mul_b         = MUL_B_W'(el_reg);
            end
            ST_DIV_RECIP:
            begin
                sat_next = n_sat;
                n_next   = n_sum[N_W-1:0];
                mul_a    = MUL_A_W'(n_sum[N_W-1:0]);
                mul_b    = MUL_B_W'(RECIP_1000);
            end
            ST_DIV_BACK:
            begin
                qe_next = qe;
                mul_a   = MUL_A_W'(qe);
                mul_b   = MUL_B_W'(DIV_CONST);
            end
            ST_DIV_FIX:
            begin
                q_next = q_fix;
            end
            ST_EXP_A:
            begin
                // a zero table entry carries through to a zero factor
                mul_a = MUL_A_W'(exp_whole_q16(x_whole));
                mul_b = MUL_B_W'(exp_sixteenth_q16(x_k));
            end
            ST_EXP_B:
            begin
                f1_next = prod_round[16 +: Q16_W];
                mul_a   = MUL_A_W'(x_r);
                mul_b   = MUL_B_W'(x_r);
            end
            ST_EXP_C:
            begin
                mul_a = MUL_A_W'(f1_reg);
                mul_b = MUL_B_W'(poly);
            end
            ST_DECAY_MUL:
            begin
                mul_a = MUL_A_W'(acc_mag);
                mul_b = MUL_B_W'(factor);
            end
            ST_DECAY_FIN:
            begin
                acc_next = acc_dec;
            end
            ST_LEVEL:
            begin
                if (!slew_en_reg || STEP_W'(diff_mag) <= step_lvl)
                    lvl_next = goal_lvl;
                else if (diff > 0)
                    lvl_next = lvl_reg + step_lvl[LVL_W-1:0];
                else
                    lvl_next = lvl_reg - step_lvl[LVL_W-1:0];
            end
            ST_BAND:
            begin
                if (natural == band_reg)
                    sustained_next = 1'b0;
                else if (span_last >= dwell_t)
                begin
                    if (!dwell_qual_reg)
                        band_take = 1'b1;
                    else if (pending_band_reg != natural)
                    begin
                        // new candidate band: restart the sustain timer
                        pending_band_next = natural;
                        cross_time_next   = now_reg;
                        sustained_next    = 1'b0;
                    end
                    else if (span_cross >= dwell_t)
                    begin
                        sustained_next = 1'b1;
                        band_take      = 1'b1;
                    end
                end
                if (band_take)
                begin
                    band_next        = natural;
                    last_change_next = now_reg;
                    changed_next     = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status_reg;
                    out_level_next   = lvl_reg;
                    out_band_next    = band_reg;
                    out_changed_next = changed_reg;
                    out_acc_next     = acc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // control and tracker state
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lvl_reg          <= LVL_RESET;
            acc_reg          <= '0;
            band_reg         <= BAND_RESET;
            pending_band_reg <= BAND_RESET;
            last_change_reg  <= '0;
            cross_time_reg   <= '0;
            sustained_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            lvl_reg          <= lvl_next;
            acc_reg          <= acc_next;
            band_reg         <= band_next;
            pending_band_reg <= pending_band_next;
            last_change_reg  <= last_change_next;
            cross_time_reg   <= cross_time_next;
            sustained_reg    <= sustained_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slew_reg   <= 24'd32768;
            decay_rate_reg <= 24'd6554;
            min_dwell_reg  <= 16'd500;
            dwell_qual_reg <= 1'b1;
            slew_en_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_SLEW:   max_slew_reg   <= cfg_data[RATE_W-1:0];
                CFG_DECAY_RATE: decay_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_MIN_DWELL:  min_dwell_reg  <= cfg_data[DWELL_W-1:0];
                CFG_DWELL_QUAL: dwell_qual_reg <= cfg_data[0];
                CFG_SLEW_EN:    slew_en_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        el_reg          <= el_next;
        now_reg         <= now_next;
        val_reg         <= val_next;
        div_slew_reg    <= div_slew_next;
        sat_reg         <= sat_next;
        n_reg           <= n_next;
        qe_reg          <= qe_next;
        q_reg           <= q_next;
        f1_reg          <= f1_next;
        status_reg      <= status_next;
        changed_reg     <= changed_next;
        out_status_reg  <= out_status_next;
        out_level_reg   <= out_level_next;
        out_band_reg    <= out_band_next;
        out_changed_reg <= out_changed_next;
        out_acc_reg     <= out_acc_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign level       = out_level_reg;
    assign band        = out_band_reg;
    assign changed     = out_changed_reg;
    assign accumulator = out_acc_reg;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------

    // reciprocal estimate is never more than one below the true quotient
    a_div_fixup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_FIX && !sat_reg) |-> (rem < N_W'(2000)))
        else $error("divide by 1000 remainder out of range");

    // an accepted band change really moves the band
    a_band_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BAND && band_take) |=> (band_reg != $past(band_reg)))
        else $error("band change taken without a new band");

    // a sustained crossing lands on the pending band
    a_sustain_band: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sustained_reg) |-> (band_reg == pending_band_reg))
        else $error("sustained crossing does not match pending band");

    // stimulus and target items leave the level alone
    a_simple_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIMPLE) |=> $stable(lvl_reg))
        else $error("non-tick item changed the level");

endmodule
